FILE: rtl/bso_pkg.sv
// bso_pkg: shared types, constants and helpers for the ball shot outcome simulator
// no dependencies; used by every module under rtl
package bso_pkg;

  localparam int CFG_W      = 31;
  localparam int DATA_W     = 32;
  localparam int POWER_W    = 23;
  localparam int SPD_W      = 25;
  localparam int NUM_W      = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int MAX_STEPS  = 1024;

  localparam logic [CFG_W-1:0] FRICTION_RST = 31'd13107;
  localparam logic [CFG_W-1:0] GRAVITY_RST  = 31'd642908;
  localparam logic [CFG_W-1:0] STEP_RST     = 31'd1092;
  localparam logic [CFG_W-1:0] STOP_RST     = 31'd655;
  localparam logic [CFG_W-1:0] RADIUS_RST   = 31'd1872;
  localparam logic [CFG_W-1:0] TLIMIT_RST   = 31'd983040;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRICTION, REG_GRAVITY, REG_STEP, REG_STOP, REG_RADIUS, REG_TLIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] friction;
    logic [CFG_W-1:0] gravity;
    logic [CFG_W-1:0] step;
    logic [CFG_W-1:0] stop;
    logic [CFG_W-1:0] radius;
    logic [CFG_W-1:0] tlimit;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DIFF, OP_SQ_A, OP_SQ_B, OP_SQRT, OP_DIST,
    OP_MUL_AX, OP_MUL_BY, OP_DIV, OP_SET_VX, OP_SET_VY,
    OP_FR1, OP_FR2, OP_FR3, OP_FR4, OP_FR5,
    OP_SQ_VX, OP_SQ_VY, OP_SET_S, OP_ZERO_V, OP_SCL_VX, OP_SCL_VY,
    OP_POS_X, OP_POS_Y, OP_POS_T, OP_SQ_EX, OP_SQ_EY, OP_HIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic zero_d;
    logic sq_busy;
    logic dv_busy;
    logic s_zero;
    logic ns_zero;
    logic run;
    logic near;
    logic hit;
    logic slow;
  } stat_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sh0007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -42'sh00080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [30:0] sat31(input logic [47:0] v);
    logic [30:0] r;
    r = (v > 48'h7FFFFFFF) ? 31'h7FFFFFFF : v[30:0];
    return r;
  endfunction

endpackage

FILE: rtl/ball_shot_outcome_simulator_core.sv
// ball_shot_outcome_simulator_core: top level, configuration registers and the
// controller / datapath pair; depends on bso_pkg, bso_ctrl, bso_dp
//
//   channel   handshake            payload
//   shot in   start, busy          start_x start_y target_x target_y shot_power
//   result    done (1-cycle)       end_x end_y end_vx end_vy elapsed_time reached
//   config    cfg_valid, cfg_ready cfg_index cfg_data
//
// one shot at a time; setup waits on the distance root and two divides, then each
// integration step waits on a speed root and, unless the ball is stopped or fully
// braked, two divides, with the hit test added near the target; at most MaxSteps
// steps run. a shot that starts on its target goes straight to done. rst clears the
// sequencer and loads the register defaults; results are not held off by the
// receiver.
module ball_shot_outcome_simulator_core
  import bso_pkg::*;
#(
  parameter int MaxSteps = MAX_STEPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  output logic                     done,
  input  logic signed [DATA_W-1:0] start_x,
  input  logic signed [DATA_W-1:0] start_y,
  input  logic signed [DATA_W-1:0] target_x,
  input  logic signed [DATA_W-1:0] target_y,
  input  logic [POWER_W-1:0]       shot_power,
  output logic signed [DATA_W-1:0] end_x,
  output logic signed [DATA_W-1:0] end_y,
  output logic signed [DATA_W-1:0] end_vx,
  output logic signed [DATA_W-1:0] end_vy,
  output logic [CFG_W-1:0]         elapsed_time,
  output logic                     reached,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.friction <= FRICTION_RST;
      cfg.gravity  <= GRAVITY_RST;
      cfg.step     <= STEP_RST;
      cfg.stop     <= STOP_RST;
      cfg.radius   <= RADIUS_RST;
      cfg.tlimit   <= TLIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRICTION: cfg.friction <= cfg_data[CFG_W-1:0];
        REG_GRAVITY:  cfg.gravity  <= cfg_data[CFG_W-1:0];
        REG_STEP:     cfg.step     <= cfg_data[CFG_W-1:0];
        REG_STOP:     cfg.stop     <= cfg_data[CFG_W-1:0];
        REG_RADIUS:   cfg.radius   <= cfg_data[CFG_W-1:0];
        REG_TLIMIT:   cfg.tlimit   <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  bso_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  bso_dp #(
    .MaxSteps (MaxSteps)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .start_x      (start_x),
    .start_y      (start_y),
    .target_x     (target_x),
    .target_y     (target_y),
    .shot_power   (shot_power),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_vx       (end_vx),
    .end_vy       (end_vy),
    .elapsed_time (elapsed_time),
    .reached      (reached)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside end of a request");
`endif

endmodule

FILE: rtl/bso_sqrt.sv
// bso_sqrt: floor square root of a 64-bit value, two radicand bits per cycle
// depends on bso_pkg
module bso_sqrt
  import bso_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] rad,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (go) begin
      busy <= 1'b1;
    end else if (busy && bitm == 64'd1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n    <= rad;
      res  <= '0;
      bitm <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (n >= trial) begin
        n   <= n - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

FILE: rtl/bso_div.sv
// bso_div: restoring divider, one quotient bit per cycle
// depends on bso_pkg (NUM_W)
module bso_div
  import bso_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [31:0]      den,
  output logic             busy,
  output logic [31:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [31:0]      rem;
  logic [32:0]      shifted;
  logic [CW-1:0]    cnt;

  assign shifted = {rem, q[NUM_W-1]};
  assign quo     = q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(NUM_W - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= num;
      rem <= '0;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        rem <= 32'(shifted - {1'b0, den});
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/bso_dp.sv
// bso_dp: datapath with one shared multiplier, square root and divider units
// depends on bso_pkg, bso_sqrt, bso_div
module bso_dp
  import bso_pkg::*;
#(
  parameter int MaxSteps = MAX_STEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  cfg_t                      cfg,
  input  logic signed [DATA_W-1:0]  start_x,
  input  logic signed [DATA_W-1:0]  start_y,
  input  logic signed [DATA_W-1:0]  target_x,
  input  logic signed [DATA_W-1:0]  target_y,
  input  logic [POWER_W-1:0]        shot_power,
  output logic signed [DATA_W-1:0]  end_x,
  output logic signed [DATA_W-1:0]  end_y,
  output logic signed [DATA_W-1:0]  end_vx,
  output logic signed [DATA_W-1:0]  end_vy,
  output logic [CFG_W-1:0]          elapsed_time,
  output logic                      reached
);

  localparam int SW = $clog2(MaxSteps + 1);

  logic signed [31:0] sx, sy, tx, ty, px, py, vx, vy;
  logic [SPD_W-1:0]   spd;
  logic [30:0]        t;
  logic [31:0]        a, b, dv;
  logic               sgx, sgy;
  logic [30:0]        fr;
  logic [63:0]        lim, stop2, acc, mp;
  logic [SW-1:0]      steps;
  logic               hit_flag;

  logic [31:0]        ma, mb;
  logic [63:0]        prod;
  logic signed [32:0] dxw, dyw, exw, eyw;
  logic [32:0]        dxm, dym, exm, eym;
  logic               big;
  logic [31:0]        ns, r2, q, root, vxm, vym;
  logic               sq_busy, dv_busy;
  logic [39:0]        dlt;
  logic [41:0]        dsum_x, dsum_y;
  logic [31:0]        tsum;

  assign dxw = {tx[31], tx} - {sx[31], sx};
  assign dyw = {ty[31], ty} - {sy[31], sy};
  assign dxm = dxw[32] ? 33'(-dxw) : 33'(dxw);
  assign dym = dyw[32] ? 33'(-dyw) : 33'(dyw);
  assign big = dxm[32] | dxm[31] | dym[32] | dym[31];
  assign exw = {px[31], px} - {tx[31], tx};
  assign eyw = {py[31], py} - {ty[31], ty};
  assign exm = exw[32] ? 33'(-exw) : 33'(exw);
  assign eym = eyw[32] ? 33'(-eyw) : 33'(eyw);
  assign ns  = (dv > {1'b0, fr}) ? dv - {1'b0, fr} : 32'd0;
  assign r2  = {cfg.radius, 1'b0};
  assign vxm = mag32(vx);
  assign vym = mag32(vy);
  assign prod = ma * mb;

  // position delta is the low 40 bits of |v|*step/65536 with the sign put back
  assign dlt    = mp[55:16];
  assign dsum_x = {{10{px[31]}}, px} + (sgx ? -{2'b0, dlt} : {2'b0, dlt});
  assign dsum_y = {{10{py[31]}}, py} + (sgy ? -{2'b0, dlt} : {2'b0, dlt});
  assign tsum   = {1'b0, t} + {1'b0, cfg.step};

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_SQ_A:   begin ma = a;   mb = a; end
      OP_SQ_B:   begin ma = b;   mb = b; end
      OP_MUL_AX: begin ma = a;   mb = 32'(spd); end
      OP_MUL_BY: begin ma = b;   mb = 32'(spd); end
      OP_FR1:    begin ma = {1'b0, cfg.friction}; mb = {1'b0, cfg.gravity}; end
      OP_FR2:    begin ma = {1'b0, sat31(mp[63:16])}; mb = {1'b0, cfg.step}; end
      OP_FR3:    begin ma = r2;  mb = r2; end
      OP_FR4:    begin ma = {1'b0, cfg.stop}; mb = {1'b0, cfg.stop}; end
      OP_SQ_VX:  begin ma = vxm; mb = vxm; end
      OP_SQ_VY:  begin ma = vym; mb = vym; end
      OP_SCL_VX: begin ma = vxm; mb = ns; end
      OP_SCL_VY: begin ma = vym; mb = ns; end
      OP_POS_X:  begin ma = vxm; mb = {1'b0, cfg.step}; end
      OP_POS_Y:  begin ma = vym; mb = {1'b0, cfg.step}; end
      OP_SQ_EX:  begin ma = exm[31:0]; mb = exm[31:0]; end
      OP_SQ_EY:  begin ma = eym[31:0]; mb = eym[31:0]; end
      default:   begin ma = '0;  mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mp <= prod;
    unique case (cmd.op)
      OP_LOAD: begin
        sx <= start_x;
        sy <= start_y;
        tx <= target_x;
        ty <= target_y;
        spd <= {2'b0, shot_power} + {1'b0, shot_power, 1'b0};
        px <= start_x;
        py <= start_y;
        vx <= '0;
        vy <= '0;
        t <= '0;
        steps <= '0;
        hit_flag <= 1'b0;
      end
      OP_DIFF: begin
        a <= big ? {1'b0, dxm[32:2]} : dxm[31:0];
        b <= big ? {1'b0, dym[32:2]} : dym[31:0];
        sgx <= dxw[32];
        sgy <= dyw[32];
      end
      OP_SQ_B, OP_SQ_VY, OP_SQ_EY: acc <= mp;
      OP_DIST:   dv <= (root == 32'd0) ? 32'd1 : root;
      OP_SET_S:  dv <= root;
      OP_SET_VX: vx <= sgx ? -$signed(q) : $signed(q);
      OP_SET_VY: vy <= sgy ? -$signed(q) : $signed(q);
      OP_FR3:    fr <= sat31(mp[63:16]);
      OP_FR4:    lim <= mp;
      OP_FR5:    stop2 <= mp;
      OP_ZERO_V: begin
        vx <= '0;
        vy <= '0;
      end
      OP_SCL_VX, OP_POS_X: sgx <= vx[31];
      OP_SCL_VY: sgy <= vy[31];
      OP_POS_Y: begin
        px  <= sat32(dsum_x);
        sgy <= vy[31];
      end
      OP_POS_T: begin
        py <= sat32(dsum_y);
        t <= tsum[31] ? 31'h7FFFFFFF : tsum[30:0];
        steps <= steps + 1'b1;
      end
      OP_HIT: hit_flag <= 1'b1;
      default: ;
    endcase
  end

  bso_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.op == OP_SQRT),
    .rad  (acc + mp),
    .busy (sq_busy),
    .root (root)
  );

  bso_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.op == OP_DIV),
    .num  (mp[NUM_W-1:0]),
    .den  (dv),
    .busy (dv_busy),
    .quo  (q)
  );

  always_comb begin
    stat.zero_d  = (tx == sx) && (ty == sy);
    stat.sq_busy = sq_busy;
    stat.dv_busy = dv_busy;
    stat.s_zero  = (dv == 32'd0);
    stat.ns_zero = (ns == 32'd0);
    stat.run     = (t < cfg.tlimit) && (steps < SW'(MaxSteps));
    stat.near    = (exm < {1'b0, r2}) && (eym < {1'b0, r2});
    stat.hit     = (acc < lim) && (mp < lim - acc);
    stat.slow    = ({1'b0, acc} + {1'b0, mp}) < {1'b0, stop2};
  end

  assign end_x        = px;
  assign end_y        = py;
  assign end_vx       = vx;
  assign end_vy       = vy;
  assign elapsed_time = t;
  assign reached      = hit_flag;

endmodule

FILE: rtl/bso_ctrl.sv
// bso_ctrl: sequencer for setup, integration steps and the end tests
// depends on bso_pkg
module bso_ctrl
  import bso_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output logic  done,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [5:0] {
    S_IDLE, S_DIFF, S_SQA, S_SQB, S_DSQ, S_DWT, S_DIST,
    S_MVX, S_DVX, S_WVX, S_MVY, S_DVY, S_WVY,
    S_FR1, S_FR2, S_FR3, S_FR4, S_FR5, S_LOOP,
    S_VSA, S_VSB, S_SSQ, S_SWT, S_SSET, S_SCHK,
    S_SMX, S_SDX, S_SWX, S_SMY, S_SDY, S_SWY,
    S_PX, S_PY, S_PT, S_NEAR, S_EXA, S_EXB, S_HCHK,
    S_STA, S_STB, S_SLOW, S_FIN
  } state_t;

  state_t state;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: if (start) cmd.op = OP_LOAD;
      S_DIFF: cmd.op = OP_DIFF;
      S_SQA:  cmd.op = OP_SQ_A;
      S_SQB:  cmd.op = OP_SQ_B;
      S_DSQ, S_SSQ: cmd.op = OP_SQRT;
      S_DIST: cmd.op = OP_DIST;
      S_MVX:  cmd.op = OP_MUL_AX;
      S_MVY:  cmd.op = OP_MUL_BY;
      S_DVX, S_DVY, S_SDX, S_SDY: cmd.op = OP_DIV;
      S_WVX, S_SWX: if (!stat.dv_busy) cmd.op = OP_SET_VX;
      S_WVY, S_SWY: if (!stat.dv_busy) cmd.op = OP_SET_VY;
      S_FR1:  cmd.op = OP_FR1;
      S_FR2:  cmd.op = OP_FR2;
      S_FR3:  cmd.op = OP_FR3;
      S_FR4:  cmd.op = OP_FR4;
      S_FR5:  cmd.op = OP_FR5;
      S_VSA, S_STA: cmd.op = OP_SQ_VX;
      S_VSB, S_STB: cmd.op = OP_SQ_VY;
      S_SSET: cmd.op = OP_SET_S;
      S_SCHK: if (!stat.s_zero && stat.ns_zero) cmd.op = OP_ZERO_V;
      S_SMX:  cmd.op = OP_SCL_VX;
      S_SMY:  cmd.op = OP_SCL_VY;
      S_PX:   cmd.op = OP_POS_X;
      S_PY:   cmd.op = OP_POS_Y;
      S_PT:   cmd.op = OP_POS_T;
      S_EXA:  cmd.op = OP_SQ_EX;
      S_EXB:  cmd.op = OP_SQ_EY;
      S_HCHK: if (stat.hit) cmd.op = OP_HIT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          state <= S_DIFF;
          busy  <= 1'b1;
        end
        S_DIFF: state <= stat.zero_d ? S_FIN : S_SQA;
        S_SQA:  state <= S_SQB;
        S_SQB:  state <= S_DSQ;
        S_DSQ:  state <= S_DWT;
        S_DWT:  if (!stat.sq_busy) state <= S_DIST;
        S_DIST: state <= S_MVX;
        S_MVX:  state <= S_DVX;
        S_DVX:  state <= S_WVX;
        S_WVX:  if (!stat.dv_busy) state <= S_MVY;
        S_MVY:  state <= S_DVY;
        S_DVY:  state <= S_WVY;
        S_WVY:  if (!stat.dv_busy) state <= S_FR1;
        S_FR1:  state <= S_FR2;
        S_FR2:  state <= S_FR3;
        S_FR3:  state <= S_FR4;
        S_FR4:  state <= S_FR5;
        S_FR5:  state <= S_LOOP;
        S_LOOP: state <= stat.run ? S_VSA : S_FIN;
        S_VSA:  state <= S_VSB;
        S_VSB:  state <= S_SSQ;
        S_SSQ:  state <= S_SWT;
        S_SWT:  if (!stat.sq_busy) state <= S_SSET;
        S_SSET: state <= S_SCHK;
        // stopped or fully braked balls skip the rescale
        S_SCHK: state <= (stat.s_zero || stat.ns_zero) ? S_PX : S_SMX;
        S_SMX:  state <= S_SDX;
        S_SDX:  state <= S_SWX;
        S_SWX:  if (!stat.dv_busy) state <= S_SMY;
        S_SMY:  state <= S_SDY;
        S_SDY:  state <= S_SWY;
        S_SWY:  if (!stat.dv_busy) state <= S_PX;
        S_PX:   state <= S_PY;
        S_PY:   state <= S_PT;
        S_PT:   state <= S_NEAR;
        S_NEAR: state <= stat.near ? S_EXA : S_STA;
        S_EXA:  state <= S_EXB;
        S_EXB:  state <= S_HCHK;
        S_HCHK: state <= stat.hit ? S_FIN : S_STA;
        S_STA:  state <= S_STB;
        S_STB:  state <= S_SLOW;
        S_SLOW: state <= stat.slow ? S_FIN : S_LOOP;
        S_FIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sim/ball_shot_outcome_simulator_core_chk.sv
// ball_shot_outcome_simulator_core_chk: watches the shot, result and config channels,
// predicts each shot outcome and compares it field by field; depends on bso_pkg
module ball_shot_outcome_simulator_core_chk
  import bso_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     done,
  input  logic signed [DATA_W-1:0] start_x,
  input  logic signed [DATA_W-1:0] start_y,
  input  logic signed [DATA_W-1:0] target_x,
  input  logic signed [DATA_W-1:0] target_y,
  input  logic [POWER_W-1:0]       shot_power,
  input  logic signed [DATA_W-1:0] end_x,
  input  logic signed [DATA_W-1:0] end_y,
  input  logic signed [DATA_W-1:0] end_vx,
  input  logic signed [DATA_W-1:0] end_vy,
  input  logic [CFG_W-1:0]         elapsed_time,
  input  logic                     reached,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       results,
  output int                       hits
);

  typedef struct {
    logic signed [31:0] x, y, vx, vy;
    logic [30:0]        t;
    logic               hit;
  } outcome_t;

  localparam bit [63:0] MAX31 = 64'h7FFF_FFFF;

  cfg_t       regs;
  outcome_t   outcome_q[$];

  function automatic bit [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit [63:0] root64(bit [63:0] n);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // magnitude scaled by num/den, truncated toward zero, sign restored
  function automatic longint ratio(longint v, bit [63:0] num, bit [63:0] den);
    bit [63:0] m;
    m = abs64(v) * num / den;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic outcome_t shot_outcome(longint sx, longint sy, longint tx, longint ty,
                                            bit [63:0] pw);
    outcome_t  o;
    longint    px, py, vx, vy, dx, dy;
    bit [63:0] spd, a, b, dlen, p1, f, r2, lim, t, s, ns, ex, ey, s1, s2, fr, gr, st;
    bit [63:0] stp, rad, tl;
    bit        hit;
    int        n;
    fr = regs.friction; gr = regs.gravity; st = regs.step;
    stp = regs.stop; rad = regs.radius; tl = regs.tlimit;
    spd = pw * 3;
    px = sx; py = sy; vx = 0; vy = 0; t = 0; hit = 0;
    dx = tx - sx; dy = ty - sy;
    if (dx != 0 || dy != 0) begin
      a = abs64(dx); b = abs64(dy);
      if (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
        a >>= 2; b >>= 2;
      end
      dlen = root64(a * a + b * b);
      if (dlen == 0) dlen = 1;
      vx = ratio(dx < 0 ? -longint'(a) : longint'(a), spd, dlen);
      vy = ratio(dy < 0 ? -longint'(b) : longint'(b), spd, dlen);
      p1 = (fr * gr) >> 16;
      if (p1 > MAX31) p1 = MAX31;
      f = (p1 * st) >> 16;
      if (f > MAX31) f = MAX31;
      r2 = 2 * rad;
      lim = r2 * r2;
      n = 0;
      while (t < tl && n < MAX_STEPS) begin
        n++;
        s = root64(64'(vx * vx) + 64'(vy * vy));
        if (s > 0) begin
          ns = (s > f) ? s - f : 0;
          if (ns > 0) begin
            vx = ratio(vx, ns, s);
            vy = ratio(vy, ns, s);
          end else begin
            vx = 0; vy = 0;
          end
        end
        px = clip32(px + ratio(vx, st, 65536));
        py = clip32(py + ratio(vy, st, 65536));
        t += st;
        if (t > MAX31) t = MAX31;
        ex = abs64(px - tx);
        ey = abs64(py - ty);
        if (ex < r2 && ey < r2) begin
          s1 = ex * ex;
          s2 = ey * ey;
          if (s1 < lim && s2 < lim - s1) begin
            hit = 1;
            break;
          end
        end
        if (64'(vx * vx) + 64'(vy * vy) < stp * stp) break;
      end
    end
    o.x = px[31:0]; o.y = py[31:0]; o.vx = vx[31:0]; o.vy = vy[31:0];
    o.t = t[30:0]; o.hit = hit;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, want);
    errors++;
  endtask

  initial begin
    errors = 0; pending = 0; results = 0; hits = 0;
  end

  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      regs <= '{FRICTION_RST, GRAVITY_RST, STEP_RST, STOP_RST, RADIUS_RST, TLIMIT_RST};
      outcome_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FRICTION: regs.friction <= cfg_data[CFG_W-1:0];
          REG_GRAVITY:  regs.gravity  <= cfg_data[CFG_W-1:0];
          REG_STEP:     regs.step     <= cfg_data[CFG_W-1:0];
          REG_STOP:     regs.stop     <= cfg_data[CFG_W-1:0];
          REG_RADIUS:   regs.radius   <= cfg_data[CFG_W-1:0];
          REG_TLIMIT:   regs.tlimit   <= cfg_data[CFG_W-1:0];
          default: ;
        endcase
      end
      if (done) begin
        results++;
        if (outcome_q.size() == 0) begin
          $display("result with no request waiting at %0t", $time);
          errors++;
        end else begin
          w = outcome_q.pop_front();
          if (end_x !== w.x) report("end_x", end_x, w.x);
          if (end_y !== w.y) report("end_y", end_y, w.y);
          if (end_vx !== w.vx) report("end_vx", end_vx, w.vx);
          if (end_vy !== w.vy) report("end_vy", end_vy, w.vy);
          if (elapsed_time !== w.t) report("elapsed_time", 32'(elapsed_time), 32'(w.t));
          if (reached !== w.hit) report("reached", 32'(reached), 32'(w.hit));
          if (w.hit) hits++;
        end
      end
      if (start && !busy)
        outcome_q.push_back(shot_outcome(start_x, start_y, target_x, target_y,
                                         64'(shot_power)));
    end
    pending = outcome_q.size();
  end

endmodule

FILE: sim/ball_shot_outcome_simulator_core_tb.sv
// ball_shot_outcome_simulator_core_tb: drives shots and register writes into the core
// and gives the verdict; depends on bso_pkg, the core and ball_shot_outcome_simulator_core_chk
module ball_shot_outcome_simulator_core_tb;
  import bso_pkg::*;

  localparam int          WATCHDOG = 1000000;
  localparam logic [30:0] MAXV     = 31'h7FFF_FFFF;
  localparam logic [22:0] PMAX     = 23'd6553600;

  logic                     clk = 0;
  logic                     rst = 1;
  logic                     start = 0;
  logic                     busy, done, reached, cfg_ready;
  logic signed [DATA_W-1:0] start_x = 0, start_y = 0, target_x = 0, target_y = 0;
  logic [POWER_W-1:0]       shot_power = 0;
  logic signed [DATA_W-1:0] end_x, end_y, end_vx, end_vy;
  logic [CFG_W-1:0]         elapsed_time;
  logic                     cfg_valid = 0;
  logic [CFG_IDX_W-1:0]     cfg_index = 0;
  logic [DATA_W-1:0]        cfg_data = 0;

  int errors, pending, results, hits;
  int sender_idle = 0;
  int shots = 0;
  int quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ball_shot_outcome_simulator_core i_dut (.*);

  ball_shot_outcome_simulator_core_chk i_chk (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG) begin
        $display("no progress for %0d cycles", WATCHDOG);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_shot(logic signed [31:0] sx, sy, tx, ty, logic [22:0] pw);
    bit taken;
    if ($urandom_range(99) < sender_idle) repeat ($urandom_range(1, 6)) @(negedge clk);
    start = 1;
    start_x = sx; start_y = sy; target_x = tx; target_y = ty; shot_power = pw;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
    start = 0;
    shots++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    bit taken;
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = {1'($urandom_range(1)), val};
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end
    cfg_valid = 0;
  endtask

  task automatic drain();
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_all(logic [30:0] fr, gr, st, sp, rd, tl);
    write_reg(REG_FRICTION, fr);
    write_reg(REG_GRAVITY, gr);
    write_reg(REG_STEP, st);
    write_reg(REG_STOP, sp);
    write_reg(REG_RADIUS, rd);
    write_reg(REG_TLIMIT, tl);
  endtask

  function automatic logic [30:0] pick(int typical);
    case ($urandom_range(5))
      0: return '0;
      1: return MAXV;
      default: return 31'($urandom_range(0, typical));
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] st, tl;
    st = ($urandom_range(3) == 0) ? 64'($urandom_range(1, MAXV)) :
                                    64'($urandom_range(500, 70000));
    // keep the step count per shot low
    tl = st * $urandom_range(1, 6);
    if (tl > 64'(MAXV)) tl = 64'(MAXV);
    if ($urandom_range(9) == 0) tl = '0;
    set_all(pick(200000), pick(1000000), st[30:0], pick(1 << 20), pick(1 << 20), tl[30:0]);
  endtask

  task automatic random_shot();
    logic signed [31:0] sx, sy, tx, ty;
    logic [22:0]        pw;
    sx = $urandom; sy = $urandom;
    case ($urandom_range(7))
      0: begin
        tx = sx; ty = sy;
      end
      1, 2: begin
        tx = $urandom; ty = $urandom;
      end
      default: begin
        tx = sx + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        ty = sy + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      end
    endcase
    case ($urandom_range(9))
      0: pw = '0;
      1: pw = PMAX;
      2: pw = 23'($urandom_range(0, 23'h3FFFFF));
      default: pw = 23'($urandom_range(0, PMAX));
    endcase
    send_shot(sx, sy, tx, ty, pw);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset defaults: start on target, a short reaching shot, a zero-power shot
    send_shot(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, PMAX);
    send_shot(0, 0, 0, 0, 23'd0);
    send_shot(0, 0, 32'sh00010000, 0, 23'h10000);
    send_shot(32'sh00020000, -32'sh00030000, -32'sh00050000, 32'sh00040000, 23'd0);
    send_shot(-32'sh00008000, 32'sh00001000, 32'sh00000000, 32'sh00009000, 23'h8000);
    drain();

    // zero time limit: start position and launch velocity come straight back
    write_reg(REG_TLIMIT, '0);
    send_shot(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, PMAX);
    send_shot(32'sh7FFFFFFF, 0, 32'sh80000000, 1, PMAX);
    send_shot(0, 32'sh7FFFFFFF, 5, 32'sh80000000, 23'h3FFFFF);
    send_shot(1, -1, 2, -2, 23'd1);
    send_shot(-100, 300, -100, 301, PMAX);
    drain();

    // register extremes (huge radius), one step each, then radius, stop and friction zero
    set_all(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_shot(0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, PMAX);
    send_shot(32'sh80000000, 32'sh12345678, 32'sh40000000, -32'sh00001000, 23'h400000);
    drain();
    write_reg(REG_RADIUS, '0);
    write_reg(REG_STOP, '0);
    write_reg(REG_FRICTION, '0);
    send_shot(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, PMAX);
    drain();

    // stop speed zero, tiny step, long limit: runs the whole step budget once
    set_all(31'd0, 31'd0, 31'd1, 31'd0, 31'd0, MAXV);
    send_shot(0, 0, 32'sh00100000, 32'sh00100000, 23'h100);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      sender_idle = (ph < 4) ? 10 : (ph < 8) ? 76 : 0;
      random_config();
      repeat (47) random_shot();
      drain();
    end

    drain();
    repeat (50) @(negedge clk);
    $display("%0d shots sent across reset defaults, register extremes and 12 random settings",
             shots);
    $display("%0d outcomes checked, %0d of them reaching the target", results, hits);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
